// ===== src/rag_pkg.sv =====
// ----------------------------------------------------------------------------
// rag_pkg
// Shared codes and the job record passed from the front end to the reducer.
// ----------------------------------------------------------------------------
package rag_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIDE_W = 64;

    typedef struct packed {
        logic [WIDE_W-1:0] nm;
        logic [WIDE_W-1:0] dm;
        logic              neg;
        logic [1:0]        st;
    } t_job;

endpackage

// ===== src/rag_front.sv =====
// ----------------------------------------------------------------------------
// rag_front
// Takes an operation, checks for a zero denominator or divisor, forms the
// products on one shared 32x32 multiplier, then emits an unreduced job.
// ----------------------------------------------------------------------------
module rag_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_a_numer,
    input  logic [31:0]          i_a_denom,
    input  logic [31:0]          i_b_numer,
    input  logic [31:0]          i_b_denom,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output rag_pkg::t_job        o_job
);
    import rag_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MP, S_MQ, S_MD, S_PUSH} t_state;

    t_state              r_state;
    logic [1:0]          r_op;
    logic [WORD_W-1:0]   r_am, r_ad, r_bm, r_bd;
    logic                r_an, r_bn, r_err;
    logic [WIDE_W-1:0]   r_p, r_q, r_d;
    logic [WORD_W-1:0]   w_mul_a, w_mul_b;
    logic [WIDE_W-1:0]   w_prod;
    logic                w_pn, w_qn;

    assign o_ready     = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);

    always_comb begin
        case (r_state)
            S_MQ: begin
                w_mul_a = r_bm;
                w_mul_b = r_ad;
            end
            S_MD: begin
                w_mul_a = r_ad;
                w_mul_b = (r_op == OP_DIV) ? r_bm : r_bd;
            end
            default: begin
                w_mul_a = r_am;
                w_mul_b = (r_op == OP_MUL) ? r_bm : r_bd;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        w_pn = r_an && (r_p != '0);
        if (r_op == OP_SUB) begin
            w_qn = (r_q != '0) && !r_bn;
        end else begin
            w_qn = r_bn && (r_q != '0);
        end
        o_job.dm = r_d;
        o_job.st = r_err ? ST_ZERO_DEN : ST_OK;
        if (r_op == OP_ADD || r_op == OP_SUB) begin
            if (w_pn == w_qn) begin
                o_job.nm  = r_p + r_q;
                o_job.neg = w_pn;
            end else if (r_p >= r_q) begin
                o_job.nm  = r_p - r_q;
                o_job.neg = w_pn;
            end else begin
                o_job.nm  = r_q - r_p;
                o_job.neg = w_qn;
            end
        end else begin
            o_job.nm  = r_p;
            o_job.neg = r_an ^ r_bn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_op;
                        r_an  <= i_a_numer[31];
                        r_bn  <= i_b_numer[31];
                        r_am  <= i_a_numer[31] ? (~i_a_numer + 32'd1) : i_a_numer;
                        r_bm  <= i_b_numer[31] ? (~i_b_numer + 32'd1) : i_b_numer;
                        r_ad  <= i_a_denom;
                        r_bd  <= i_b_denom;
                        r_err <= (i_a_denom == '0) || (i_b_denom == '0) ||
                                 ((i_op == OP_DIV) && (i_b_numer == '0));
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_p     <= w_prod;
                    r_state <= S_MQ;
                end
                S_MQ: begin
                    r_q     <= w_prod;
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_d     <= w_prod;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/rag_queue.sv =====
// ----------------------------------------------------------------------------
// rag_queue
// Two-entry job queue between the front end and the reducer.
// ----------------------------------------------------------------------------
module rag_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  rag_pkg::t_job i_job,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output rag_pkg::t_job o_job
);
    import rag_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_job        = r_mem[r_rp];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

// ===== src/rag_back.sv =====
// ----------------------------------------------------------------------------
// rag_back
// Reducer: binary GCD one step per cycle, then two restoring dividers in
// parallel, range check and an output register.
// ----------------------------------------------------------------------------
module rag_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  rag_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_numer,
    output logic [31:0]   o_denom,
    output logic [1:0]    o_status
);
    import rag_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_GCD, S_DIV, S_FIN} t_state;

    t_state             r_state;
    logic [WIDE_W-1:0]  r_u, r_v, r_g;
    logic [WIDE_W-1:0]  r_jn, r_jd;
    logic [5:0]         r_k, r_cnt;
    logic [WIDE_W-1:0]  r_nr, r_nq, r_dr, r_dq;
    logic               r_neg;
    logic [1:0]         r_st;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_n, r_out_d;
    logic [1:0]         r_out_st;
    logic [WIDE_W:0]    w_nt, w_dt;
    logic               w_nge, w_dge, w_ovf;
    logic [WORD_W-1:0]  w_lim;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_valid   = r_out_valid;
    assign o_numer   = r_out_n;
    assign o_denom   = r_out_d;
    assign o_status  = r_out_st;

    assign w_nt  = {r_nr, r_nq[WIDE_W-1]};
    assign w_dt  = {r_dr, r_dq[WIDE_W-1]};
    assign w_nge = (w_nt >= {1'b0, r_g});
    assign w_dge = (w_dt >= {1'b0, r_g});
    assign w_lim = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_ovf = (r_dq[WIDE_W-1:WORD_W] != '0) || (r_nq[WIDE_W-1:WORD_W] != '0) ||
                   (r_nq[WORD_W-1:0] > w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_u   <= i_job.nm;
                        r_v   <= i_job.dm;
                        r_jn  <= i_job.nm;
                        r_jd  <= i_job.dm;
                        r_k   <= '0;
                        r_neg <= ((i_job.st == ST_OK) && (i_job.nm != '0)) ? i_job.neg
                                                                            : 1'b0;
                        r_st  <= i_job.st;
                        r_nq  <= '0;
                        r_dq  <= 64'd1;
                        if (i_job.st != ST_OK || i_job.nm == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (r_u == '0 || r_v == '0) begin
                        r_g     <= (r_u | r_v) << r_k;
                        r_nr    <= '0;
                        r_dr    <= '0;
                        r_nq    <= r_jn;
                        r_dq    <= r_jd;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= (r_u - r_v) >> 1;
                    end else begin
                        r_v <= (r_v - r_u) >> 1;
                    end
                end
                S_DIV: begin
                    r_nr  <= w_nge ? 64'(w_nt - {1'b0, r_g}) : w_nt[WIDE_W-1:0];
                    r_dr  <= w_dge ? 64'(w_dt - {1'b0, r_g}) : w_dt[WIDE_W-1:0];
                    r_nq  <= {r_nq[WIDE_W-2:0], w_nge};
                    r_dq  <= {r_dq[WIDE_W-2:0], w_dge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        if (r_st != ST_OK || w_ovf) begin
                            r_out_st <= (r_st != ST_OK) ? r_st : ST_OVERFLOW;
                            r_out_n  <= '0;
                            r_out_d  <= 32'd1;
                        end else begin
                            r_out_st <= ST_OK;
                            r_out_n  <= r_neg ? (~r_nq[WORD_W-1:0] + 32'd1)
                                              : r_nq[WORD_W-1:0];
                            r_out_d  <= r_dq[WORD_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/rational_arith_gcd_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce
// Fraction add, subtract, multiply and divide with GCD reduction.
// ----------------------------------------------------------------------------
// One operation per transfer. The front end forms 3 products on a shared
// 32x32 multiplier and issues the job into a queue of up to two jobs. The
// reducer then runs one binary-GCD step per cycle and the two parallel
// restoring dividers; error and zero results skip both. The front end takes
// a new operation only once its job is queued, and the reducer takes a new
// job only once the last result is in its output register. Status 1 flags a
// zero denominator or divide by zero, status 2 a reduced result outside 32
// bits; both return 0/1.
module rational_arith_gcd_reduce (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_numer, a_denom, b_numer, b_denom
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_numer, res_denom
    output logic [1:0]   m_axis_tuser   // status
);
    import rag_pkg::*;

    t_job w_fjob, w_qjob;
    logic w_fvalid, w_fready, w_qvalid, w_qpop;

    rag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_a_numer   (s_axis_tdata[31:0]),
        .i_a_denom   (s_axis_tdata[63:32]),
        .i_b_numer   (s_axis_tdata[95:64]),
        .i_b_denom   (s_axis_tdata[127:96]),
        .o_job_valid (w_fvalid),
        .i_job_ready (w_fready),
        .o_job       (w_fjob)
    );

    rag_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_fvalid),
        .o_push_ready (w_fready),
        .i_job        (w_fjob),
        .o_pop_valid  (w_qvalid),
        .i_pop        (w_qpop),
        .o_job        (w_qjob)
    );

    rag_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .o_job_pop   (w_qpop),
        .i_job       (w_qjob),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_numer     (m_axis_tdata[31:0]),
        .o_denom     (m_axis_tdata[63:32]),
        .o_status    (m_axis_tuser)
    );

endmodule

// ===== src/rag_checker.sv =====
// ----------------------------------------------------------------------------
// rag_checker
// Port-level checks on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
module rag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import rag_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |->
            (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[63:32] == 32'd1))
        else $error("error result not 0/1");

    a_ok_denom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |-> (m_axis_tdata[63:32] != 32'd0))
        else $error("zero denominator on ok result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_ZERO_DEN ||
                           m_axis_tuser == ST_OVERFLOW))
        else $error("bad status code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind rational_arith_gcd_reduce rag_checker u_rag_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives fraction operations into the reducer and compares every reduced
// result, field by field, with an in-bench predictor of the exact fraction
// arithmetic, across phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
module testbench;
    import rag_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } t_frac_op;

    typedef struct packed {
        logic [31:0] numer;
        logic [31:0] denom;
        logic [1:0]  st;
    } t_frac_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    t_frac_op  op_pending[$];
    t_frac_res reduced_due[$];
    int        src_idle_pct;
    int        snk_stall_pct;
    bit        failed;
    bit        busy_slot;

    rational_arith_gcd_reduce DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_frac_res reduce_frac(t_frac_op f);
        t_frac_res   res;
        logic [63:0] am, bm, ad, bd, p, q, nm, dm, g;
        logic        an, bn, pn, qn, neg;
        an = f.an[31];
        bn = f.bn[31];
        am = {32'd0, an ? -f.an : f.an};
        bm = {32'd0, bn ? -f.bn : f.bn};
        ad = {32'd0, f.ad};
        bd = {32'd0, f.bd};
        nm = 0;
        dm = 1;
        neg = 1'b0;
        res = '{numer: 32'd0, denom: 32'd1, st: ST_OK};
        if (ad == 0 || bd == 0 || (f.op == OP_DIV && bm == 0)) begin
            res.st = ST_ZERO_DEN;
            return res;
        end
        case (f.op)
            OP_ADD, OP_SUB: begin
                p = am * bd;
                q = bm * ad;
                pn = an && p != 0;
                qn = (bn && q != 0);
                if (f.op == OP_SUB) qn = !qn && q != 0;
                if (pn == qn) begin
                    nm = p + q;
                    neg = pn;
                end else if (p >= q) begin
                    nm = p - q;
                    neg = pn;
                end else begin
                    nm = q - p;
                    neg = qn;
                end
                dm = ad * bd;
            end
            OP_MUL: begin
                nm = am * bm;
                neg = an != bn;
                dm = ad * bd;
            end
            default: begin
                nm = am * bd;
                neg = an != bn;
                dm = ad * bm;
            end
        endcase
        if (nm == 0) begin
            neg = 1'b0;
            dm = 1;
        end else begin
            g = gcd64(nm, dm);
            nm = nm / g;
            dm = dm / g;
        end
        if (dm > 64'hFFFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            res.st = ST_OVERFLOW;
            return res;
        end
        res.numer = neg ? -nm[31:0] : nm[31:0];
        res.denom = dm[31:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 12);
            1: return -$urandom_range(1, 12);
            2: return $urandom_range(0, 1000);
            3: return -$urandom_range(0, 1000);
            4: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_denom();
        logic [31:0] d;
        d = rand_word();
        if ($urandom_range(0, 99) < 70) d = $urandom_range(1, 5000);
        if ($urandom_range(0, 99) < 4) d = 32'd0;
        return d;
    endfunction

    task automatic push_op(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
        op_pending.push_back('{op: op, an: an, ad: ad, bn: bn, bd: bd});
    endtask

    // input transfers
    always @(posedge i_clk) begin
        if (i_rst_n && busy_slot && s_axis_tvalid && s_axis_tready) begin
            reduced_due.push_back(reduce_frac(op_pending.pop_front()));
            busy_slot = 1'b0;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            busy_slot = 1'b0;
        end else begin
            if (!busy_slot) begin
                if (op_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= op_pending[0].op;
                    s_axis_tdata  <= {op_pending[0].bd, op_pending[0].bn,
                                      op_pending[0].ad, op_pending[0].an};
                    busy_slot = 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frac_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{numer: m_axis_tdata[31:0], denom: m_axis_tdata[63:32],
                    st: m_axis_tuser};
            if (reduced_due.size() == 0) begin
                $display("%0t: result with none expected: %h/%h st %0d",
                         $time, got.numer, got.denom, got.st);
                failed = 1'b1;
            end else begin
                want = reduced_due.pop_front();
                if (got.numer !== want.numer) begin
                    $display("%0t: numer expected %h actual %h", $time, want.numer, got.numer);
                    failed = 1'b1;
                end
                if (got.denom !== want.denom) begin
                    $display("%0t: denom expected %h actual %h", $time, want.denom, got.denom);
                    failed = 1'b1;
                end
                if (got.st !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase;
        failed = 1'b0;
        busy_slot = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADD;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes and special cases
        push_op(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_op(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        push_op(OP_SUB, 32'h8000_0000, 1, 32'd1, 1);
        push_op(OP_SUB, 3, 4, 3, 4);
        push_op(OP_MUL, 32'h8000_0000, 1, -32'sd1, 1);
        push_op(OP_MUL, 32'h8000_0000, 1, 32'd1, 1);
        push_op(OP_MUL, 1, 32'hFFFF_FFFF, 1, 2);
        push_op(OP_DIV, 1, 2, -32'sd3, 4);
        push_op(OP_DIV, 5, 7, 0, 9);
        push_op(OP_ADD, 1, 0, 1, 1);
        push_op(OP_MUL, 1, 1, 1, 0);
        push_op(OP_DIV, 0, 5, 7, 3);
        push_op(OP_MUL, 0, 9, -32'sd5, 3);
        push_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_op(OP_DIV, 6, 1, -32'sd4, 1);
        push_op(OP_SUB, -32'sd1, 3, -32'sd2, 5);
        push_op(OP_ADD, 32'hFFFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 16; snk_stall_pct = 16; end
            endcase
            repeat (125) push_op(2'($urandom_range(0, 3)), rand_word(), rand_denom(),
                                 rand_word(), rand_denom());
            while (op_pending.size() > 0) @(posedge i_clk);
        end
        while (reduced_due.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
